@@ hdl/suv_pkg.sv @@
// shared types and constants for the surface uv derivative solver
`timescale 1ns / 1ps
package suv_pkg;

  // fraction bits of the Q16.16 results
  localparam int FRAC_BITS = 16;

  // dominant axis of the normal
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

endpackage

@@ hdl/suv_if.sv @@
// valid/ready channel interfaces for input beats and result beats
`timescale 1ns / 1ps
interface suv_in_if #(
  parameter int COMP_WIDTH = 20
);
  logic                      valid;
  logic                      ready;
  logic [3*COMP_WIDTH-1:0]   pos_deriv_x;
  logic [3*COMP_WIDTH-1:0]   pos_deriv_y;
  logic [3*COMP_WIDTH-1:0]   tangent_u;
  logic [3*COMP_WIDTH-1:0]   tangent_v;
  logic [3*COMP_WIDTH-1:0]   normal;

  modport source (output valid, pos_deriv_x, pos_deriv_y, tangent_u, tangent_v, normal,
                  input ready);
  modport sink (input valid, pos_deriv_x, pos_deriv_y, tangent_u, tangent_v, normal,
                output ready);
endinterface

interface suv_out_if #(
  parameter int OUT_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] du_dx;
  logic signed [OUT_WIDTH-1:0] dv_dx;
  logic signed [OUT_WIDTH-1:0] du_dy;
  logic signed [OUT_WIDTH-1:0] dv_dy;
  logic                        degenerate;

  modport source (output valid, du_dx, dv_dx, du_dy, dv_dy, degenerate, input ready);
  modport sink (input valid, du_dx, dv_dx, du_dy, dv_dy, degenerate, output ready);
endinterface

@@ hdl/suv_proj.sv @@
// projection, cross products and determinant: three register stages
`timescale 1ns / 1ps
module suv_proj #(
  parameter int CW = 20,
  parameter int DW = 2 * CW + 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [3*CW-1:0]      pdx,
  input  logic [3*CW-1:0]      pdy,
  input  logic [3*CW-1:0]      tu,
  input  logic [3*CW-1:0]      tv,
  input  logic [3*CW-1:0]      nrm,
  output logic signed [DW-1:0] det,
  output logic signed [DW-1:0] num0,
  output logic signed [DW-1:0] num1,
  output logic signed [DW-1:0] num2,
  output logic signed [DW-1:0] num3
);
  import suv_pkg::*;

  localparam int PW = 2 * CW;

  logic [CW-1:0]        mag_x, mag_y, mag_z;
  axis_t                axis;
  logic signed [CW-1:0] sel_nxt [0:7];
  logic signed [CW-1:0] sel_r   [0:7];
  logic signed [PW-1:0] prd_r   [0:9];
  logic signed [DW-1:0] det_r, num0_r, num1_r, num2_r, num3_r;

  // magnitudes of the normal components
  always_comb begin
    mag_x = nrm[CW-1]     ? CW'(-nrm[CW-1:0])     : nrm[CW-1:0];
    mag_y = nrm[2*CW-1]   ? CW'(-nrm[2*CW-1:CW])  : nrm[2*CW-1:CW];
    mag_z = nrm[3*CW-1]   ? CW'(-nrm[3*CW-1:2*CW]) : nrm[3*CW-1:2*CW];
  end

  // largest axis, lower axis wins ties
  always_comb begin
    axis = AXIS_X;
    if (mag_y > mag_x) begin
      axis = AXIS_Y;
      if (mag_z > mag_y) axis = AXIS_Z;
    end else if (mag_z > mag_x) begin
      axis = AXIS_Z;
    end
  end

  // pick the two cyclic components of each vector
  always_comb begin
    unique case (axis)
      AXIS_Y: begin
        sel_nxt[0] = pdx[3*CW-1:2*CW]; sel_nxt[1] = pdx[CW-1:0];
        sel_nxt[2] = pdy[3*CW-1:2*CW]; sel_nxt[3] = pdy[CW-1:0];
        sel_nxt[4] = tu[3*CW-1:2*CW];  sel_nxt[5] = tu[CW-1:0];
        sel_nxt[6] = tv[3*CW-1:2*CW];  sel_nxt[7] = tv[CW-1:0];
      end
      AXIS_Z: begin
        sel_nxt[0] = pdx[CW-1:0]; sel_nxt[1] = pdx[2*CW-1:CW];
        sel_nxt[2] = pdy[CW-1:0]; sel_nxt[3] = pdy[2*CW-1:CW];
        sel_nxt[4] = tu[CW-1:0];  sel_nxt[5] = tu[2*CW-1:CW];
        sel_nxt[6] = tv[CW-1:0];  sel_nxt[7] = tv[2*CW-1:CW];
      end
      default: begin
        sel_nxt[0] = pdx[2*CW-1:CW]; sel_nxt[1] = pdx[3*CW-1:2*CW];
        sel_nxt[2] = pdy[2*CW-1:CW]; sel_nxt[3] = pdy[3*CW-1:2*CW];
        sel_nxt[4] = tu[2*CW-1:CW];  sel_nxt[5] = tu[3*CW-1:2*CW];
        sel_nxt[6] = tv[2*CW-1:CW];  sel_nxt[7] = tv[3*CW-1:2*CW];
      end
    endcase
  end

  // stage 1: projected components
  always_ff @(posedge clk) begin
    if (en) sel_r <= sel_nxt;
  end

  // stage 2: exact products
  always_ff @(posedge clk) begin
    if (en) begin
      prd_r[0] <= PW'(sel_r[4]) * PW'(sel_r[7]);
      prd_r[1] <= PW'(sel_r[6]) * PW'(sel_r[5]);
      prd_r[2] <= PW'(sel_r[0]) * PW'(sel_r[7]);
      prd_r[3] <= PW'(sel_r[6]) * PW'(sel_r[1]);
      prd_r[4] <= PW'(sel_r[4]) * PW'(sel_r[1]);
      prd_r[5] <= PW'(sel_r[0]) * PW'(sel_r[5]);
      prd_r[6] <= PW'(sel_r[2]) * PW'(sel_r[7]);
      prd_r[7] <= PW'(sel_r[6]) * PW'(sel_r[3]);
      prd_r[8] <= PW'(sel_r[4]) * PW'(sel_r[3]);
      prd_r[9] <= PW'(sel_r[2]) * PW'(sel_r[5]);
    end
  end

  // stage 3: determinant and numerators
  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= DW'(prd_r[0]) - DW'(prd_r[1]);
      num0_r <= DW'(prd_r[2]) - DW'(prd_r[3]);
      num1_r <= DW'(prd_r[4]) - DW'(prd_r[5]);
      num2_r <= DW'(prd_r[6]) - DW'(prd_r[7]);
      num3_r <= DW'(prd_r[8]) - DW'(prd_r[9]);
    end
  end

  assign det  = det_r;
  assign num0 = num0_r;
  assign num1 = num1_r;
  assign num2 = num2_r;
  assign num3 = num3_r;
endmodule

@@ hdl/suv_div.sv @@
// pipelined restoring divider lane: rounded, saturated num * 2^16 / det
`timescale 1ns / 1ps
module suv_div #(
  parameter int DW = 41,
  parameter int OW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [OW-1:0] res,
  output logic                 zero
);
  import suv_pkg::*;

  localparam int QB  = OW + 1;
  localparam int NW  = DW + FRAC_BITS;
  localparam int NWP = NW + 1;
  localparam int EW  = (NWP > QB) ? NWP : QB;

  logic [DW-1:0]  mag_n, mag_d;
  logic [NW-1:0]  n_sh;
  logic [EW-1:0]  n_ext, n_hi;
  logic           ovf_nxt;

  logic [DW-1:0]  rem_r  [0:QB];
  logic [QB-1:0]  low_r  [0:QB];
  logic [QB-1:0]  q_r    [0:QB];
  logic [DW-1:0]  d_r    [0:QB];
  logic           neg_r  [0:QB];
  logic           zero_r [0:QB];
  logic           ovf_r  [0:QB];

  logic [QB-1:0]  q_fin;
  logic [QB-1:0]  lim;
  logic [OW-1:0]  res_nxt;
  logic [OW-1:0]  res_r;
  logic           zero_out_r;

  // magnitudes, half divisor added for round half away from zero
  always_comb begin
    mag_n   = num[DW-1] ? DW'(-num) : DW'(num);
    mag_d   = den[DW-1] ? DW'(-den) : DW'(den);
    n_sh    = {mag_n, FRAC_BITS'(0)};
    n_ext   = EW'(NWP'(n_sh) + NWP'(mag_d >> 1));
    n_hi    = n_ext >> QB;
    ovf_nxt = n_hi >= EW'(mag_d);
  end

  // prep stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DW'(n_hi);
      low_r[0]  <= n_ext[QB-1:0];
      q_r[0]    <= '0;
      d_r[0]    <= mag_d;
      neg_r[0]  <= num[DW-1] ^ den[DW-1];
      zero_r[0] <= (den == '0);
      ovf_r[0]  <= ovf_nxt;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [DW:0] trial;
    logic        take;

    always_comb begin
      trial = {rem_r[k], low_r[k][QB-1]};
      take  = trial >= {1'b0, d_r[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= take ? DW'(trial - {1'b0, d_r[k]}) : DW'(trial);
        low_r[k+1]  <= {low_r[k][QB-2:0], 1'b0};
        q_r[k+1]    <= {q_r[k][QB-2:0], take};
        d_r[k+1]    <= d_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        ovf_r[k+1]  <= ovf_r[k];
      end
    end
  end

  // sign, saturation and degenerate zeroing
  always_comb begin
    q_fin = q_r[QB];
    lim   = QB'(1) << (OW - 1);
    if (zero_r[QB]) begin
      res_nxt = '0;
    end else if (neg_r[QB]) begin
      res_nxt = (ovf_r[QB] || q_fin > lim) ? lim[OW-1:0] : OW'(-q_fin[OW-1:0]);
    end else begin
      res_nxt = (ovf_r[QB] || q_fin > lim - QB'(1)) ? OW'(lim - QB'(1)) : q_fin[OW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      res_r      <= res_nxt;
      zero_out_r <= zero_r[QB];
    end
  end

  assign res  = res_r;
  assign zero = zero_out_r;
endmodule

@@ hdl/surface_uv_derivative_solver_core.sv @@
// top level: projection pipeline feeding four divider lanes
//
//  channel | dir | beat contents
//  in_ch   | in  | pos_deriv_x, pos_deriv_y, tangent_u, tangent_v, normal
//  out_ch  | out | du_dx, dv_dx, du_dy, dv_dy, degenerate
//
// one beat accepted per cycle while the pipe is not held; a beat passes through
// three projection stages, a prep stage, OUT_WIDTH + 1 quotient-bit stages
// and the result register.
// rst_n clears only the valid bits; payload registers carry no reset.
// a stalled result freezes the whole pipe, so nothing is dropped or repeated.
`timescale 1ns / 1ps
module surface_uv_derivative_solver_core #(
  parameter int COMP_WIDTH = 20,
  parameter int OUT_WIDTH  = 32
) (
  input logic clk,
  input logic rst_n,
  suv_in_if.sink    in_ch,
  suv_out_if.source out_ch
);
  import suv_pkg::*;

  localparam int DW  = 2 * COMP_WIDTH + 1;
  localparam int LAT = OUT_WIDTH + 6;

  logic                  adv;
  logic [LAT-1:0]        vld_r;
  logic signed [DW-1:0]  det, num0, num1, num2, num3;
  logic                  z0, z1, z2, z3;

  // whole pipe moves unless the last result is held
  assign adv = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  suv_proj #(.CW(COMP_WIDTH), .DW(DW)) u_proj (
    .clk(clk), .en(adv),
    .pdx(in_ch.pos_deriv_x), .pdy(in_ch.pos_deriv_y),
    .tu(in_ch.tangent_u), .tv(in_ch.tangent_v), .nrm(in_ch.normal),
    .det(det), .num0(num0), .num1(num1), .num2(num2), .num3(num3)
  );

  // four divider lanes sharing one determinant
  suv_div #(.DW(DW), .OW(OUT_WIDTH)) u_div0 (
    .clk(clk), .en(adv), .num(num0), .den(det), .res(out_ch.du_dx), .zero(z0));
  suv_div #(.DW(DW), .OW(OUT_WIDTH)) u_div1 (
    .clk(clk), .en(adv), .num(num1), .den(det), .res(out_ch.dv_dx), .zero(z1));
  suv_div #(.DW(DW), .OW(OUT_WIDTH)) u_div2 (
    .clk(clk), .en(adv), .num(num2), .den(det), .res(out_ch.du_dy), .zero(z2));
  suv_div #(.DW(DW), .OW(OUT_WIDTH)) u_div3 (
    .clk(clk), .en(adv), .num(num3), .den(det), .res(out_ch.dv_dy), .zero(z3));

  assign out_ch.valid      = vld_r[LAT-1];
  assign out_ch.degenerate = z0;

  // a degenerate result carries all-zero derivatives
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.du_dx == '0 && out_ch.dv_dx == '0 && out_ch.du_dy == '0 && out_ch.dv_dy == '0)
    else $error("degenerate beat with nonzero derivative");

  // all lanes see the same determinant
  a_lane_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> z0 == z1 && z1 == z2 && z2 == z3)
    else $error("divider lanes disagree on zero determinant");

  // an accepted beat enters the first valid stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted beat lost at pipe entry");

  // a held pipe keeps its valid bits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid bits moved during stall");
endmodule
